// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated property checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define GNO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GNO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/gno_pkg.sv
// ----------------------------------------------------------------------------
// gno_pkg
// Shared constants, types and helpers for the grid neighbour block.
// ----------------------------------------------------------------------------
package gno_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = 9;
  localparam int CELL_W    = 16;
  localparam int ROW_W     = $clog2(MAX_SIDE);
  localparam int DIR_W     = 3;
  localparam int NUM_DIR   = 8;
  localparam int OFF_W     = 10;
  localparam int REG_W     = 4;
  localparam int SQ_W      = 2 * SIDE_W;
  localparam int DIV_STEPS = ROW_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);

  // line class of a row or column
  localparam logic [1:0] CLS_FIRST = 2'd0;
  localparam logic [1:0] CLS_MID   = 2'd1;
  localparam logic [1:0] CLS_LAST  = 2'd2;

  // direction codes, row-major in the 3x3 window
  localparam logic [DIR_W-1:0] DIR_UL = 3'd0;
  localparam logic [DIR_W-1:0] DIR_U  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UR = 3'd2;
  localparam logic [DIR_W-1:0] DIR_L  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_R  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_DL = 3'd5;
  localparam logic [DIR_W-1:0] DIR_D  = 3'd6;
  localparam logic [DIR_W-1:0] DIR_DR = 3'd7;

  // an out-of-grid index yields a single result
  localparam logic [NUM_DIR-1:0] BAD_MASK = 8'b0000_0001;

  typedef struct packed {
    logic                bad;
    logic [REG_W-1:0]    region;
    logic [NUM_DIR-1:0]  mask;
    logic [CELL_W-1:0]   idx;
  } nbr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    r = s;
    if (s < SIDE_W'(2)) r = SIDE_W'(2);
    if (s > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

// File: sv/gno_front.sv
// ----------------------------------------------------------------------------
// gno_front
// Accepts cell indices, splits them into row and column with a two-bit per
// cycle restoring divider and classes the cell into its border region.
// ----------------------------------------------------------------------------
module gno_front import gno_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIDE_W-1:0]   side_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CELL_W-1:0]   cell_index_i,
  input  fifo_stat_t          fifo_stat_i,
  output logic                push_o,
  output nbr_item_t           push_item_o
);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CELL_W-1:0] rem_q, rem_d;
  logic [ROW_W-1:0]  quo_q, quo_d;
  logic [CELL_W-1:0] idx_q;
  logic              bad_q;

  logic              done;
  logic              accept;
  logic              bad_in;
  logic [SQ_W-1:0]   side_sq;
  logic [1:0]        rcls, ccls;
  logic [ROW_W-1:0]  col;

  assign side_sq = SQ_W'(side_i) * SQ_W'(side_i);
  assign bad_in  = SQ_W'(cell_index_i) >= side_sq;

  assign done       = busy_q && (cnt_q == CNT_W'(DIV_STEPS));
  assign push_o     = done && !fifo_stat_i.full;
  assign in_ready_o = !busy_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // two quotient bits per cycle, msb first
  always_comb begin
    logic [2:0]        b;
    logic [CELL_W:0]   dvs;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      b   = 3'(ROW_W - 1) - {cnt_q[1:0], 1'b0} - 3'(k);
      dvs = (CELL_W + 1)'(side_i) << b;
      if ({1'b0, rem_d} >= dvs) begin
        rem_d    = rem_d - dvs[CELL_W-1:0];
        quo_d[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      bad_q  <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      bad_q  <= bad_in;
    end else if (busy_q && !done) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (push_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q <= cell_index_i;
      quo_q <= '0;
      idx_q <= cell_index_i;
    end else if (busy_q && !done) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign col = rem_q[ROW_W-1:0];

  always_comb begin
    if (quo_q == '0) rcls = CLS_FIRST;
    else if (SIDE_W'(quo_q) == side_i - SIDE_W'(1)) rcls = CLS_LAST;
    else rcls = CLS_MID;
    if (col == '0) ccls = CLS_FIRST;
    else if (SIDE_W'(col) == side_i - SIDE_W'(1)) ccls = CLS_LAST;
    else ccls = CLS_MID;
  end

  always_comb begin
    logic up_ok, dn_ok, lf_ok, rt_ok;
    up_ok = rcls != CLS_FIRST;
    dn_ok = rcls != CLS_LAST;
    lf_ok = ccls != CLS_FIRST;
    rt_ok = ccls != CLS_LAST;
    push_item_o.idx = idx_q;
    if (bad_q) begin
      push_item_o.bad    = 1'b1;
      push_item_o.region = '0;
      push_item_o.mask   = BAD_MASK;
    end else begin
      push_item_o.bad    = 1'b0;
      push_item_o.region = REG_W'({rcls, 1'b0}) + REG_W'(rcls) + REG_W'(ccls);
      push_item_o.mask   = {dn_ok && rt_ok, dn_ok, dn_ok && lf_ok, rt_ok,
                            lf_ok, up_ok && rt_ok, up_ok, up_ok && lf_ok};
    end
  end

endmodule

// File: sv/gno_fifo.sv
// ----------------------------------------------------------------------------
// gno_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module gno_fifo import gno_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  nbr_item_t   push_item_i,
  input  logic        pop_i,
  output nbr_item_t   head_o,
  output fifo_stat_t  stat_o
);

  nbr_item_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;

  assign stat_o.full  = count_q == FCNT_W'(FIFO_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i) count_q <= count_q + FCNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// File: sv/gno_back.sv
// ----------------------------------------------------------------------------
// gno_back
// Walks the neighbour mask of the current item and emits one result per
// cycle, unless held by out_ready_i, into a registered output stage.
// ----------------------------------------------------------------------------
module gno_back import gno_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [SIDE_W-1:0]         side_i,
  input  nbr_item_t                 head_i,
  input  fifo_stat_t                fifo_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIR_W-1:0]          direction_o,
  output logic signed [OFF_W-1:0]   offset_o,
  output logic [CELL_W-1:0]         neighbor_index_o,
  output logic [REG_W-1:0]          region_o,
  output logic                      bad_cell_o,
  output logic                      last_o
);

  logic               cur_valid_q;
  nbr_item_t          cur_q;
  logic [NUM_DIR-1:0] mask_q;

  logic               out_valid_q;
  logic [DIR_W-1:0]   dir_q;
  logic signed [OFF_W-1:0] off_q;
  logic [CELL_W-1:0]  nbr_q;
  logic [REG_W-1:0]   reg_q;
  logic               bad_q, last_q;

  logic               load_out, finish;
  logic [DIR_W-1:0]   sel;
  logic [NUM_DIR-1:0] sel_oh, rest;
  logic signed [OFF_W-1:0] side_s, off;

  // lowest pending direction first
  always_comb begin
    sel = '0;
    for (int i = NUM_DIR - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = DIR_W'(i);
    end
  end

  assign sel_oh = NUM_DIR'(1) << sel;
  assign rest   = mask_q & ~sel_oh;

  assign load_out = cur_valid_q && (!out_valid_q || out_ready_i);
  assign finish   = load_out && (rest == '0);
  assign pop_o    = !fifo_stat_i.empty && (!cur_valid_q || finish);

  assign side_s = signed'({1'b0, side_i});

  always_comb begin
    case (sel)
      DIR_UL:  off = -side_s - OFF_W'(1);
      DIR_U:   off = -side_s;
      DIR_UR:  off = -side_s + OFF_W'(1);
      DIR_L:   off = -OFF_W'(1);
      DIR_R:   off = OFF_W'(1);
      DIR_DL:  off = side_s - OFF_W'(1);
      DIR_D:   off = side_s;
      DIR_DR:  off = side_s + OFF_W'(1);
      default: off = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) cur_valid_q <= 1'b1;
      else if (finish) cur_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= head_i;
      mask_q <= head_i.mask;
    end else if (load_out) begin
      mask_q <= rest;
    end
    if (load_out) begin
      last_q <= rest == '0;
      bad_q  <= cur_q.bad;
      if (cur_q.bad) begin
        dir_q <= '0;
        off_q <= '0;
        nbr_q <= '0;
        reg_q <= '0;
      end else begin
        dir_q <= sel;
        off_q <= off;
        nbr_q <= cur_q.idx + {{(CELL_W - OFF_W){off[OFF_W-1]}}, off};
        reg_q <= cur_q.region;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign direction_o      = dir_q;
  assign offset_o         = off_q;
  assign neighbor_index_o = nbr_q;
  assign region_o         = reg_q;
  assign bad_cell_o       = bad_q;
  assign last_o           = last_q;

endmodule

// File: sv/grid_neighbor_offsets.sv
// ----------------------------------------------------------------------------
// grid_neighbor_offsets
// For each centre cell on a square grid, lists its 8-connected neighbours
// that lie inside the grid, in row-major window order.
// ----------------------------------------------------------------------------
// Each item gives one result per in-grid neighbour: 3 at a corner, 5 on an
// edge, 8 inside, and 1 for an index outside the grid. Results leave at one
// per cycle while out_ready_i does not hold the output. The front end splits
// the index with a restoring divider resolving two row bits per cycle and
// takes a new index only once the last one is pushed; a two-entry queue lets
// it work on the next item while the back end is still emitting.
// grid_side is taken as 2..256 (smaller values act as 2, larger as 256) and
// must only be written while no item is in flight.
module grid_neighbor_offsets import gno_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SIDE_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CELL_W-1:0]         cell_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIR_W-1:0]          direction_o,
  output logic signed [OFF_W-1:0]   offset_o,
  output logic [CELL_W-1:0]         neighbor_index_o,
  output logic [REG_W-1:0]          region_o,
  output logic                      bad_cell_o,
  output logic                      last_o
);

`include "assert_macros.svh"

  logic [SIDE_W-1:0] grid_side_q;
  logic [SIDE_W-1:0] side;
  logic              push, pop;
  nbr_item_t         push_item, head;
  fifo_stat_t        fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= SIDE_W'(128);
    end else if (cfg_we_i) begin
      grid_side_q <= cfg_data_i;
    end
  end

  assign side = eff_side(grid_side_q);

  gno_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .side_i       (side),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_index_i (cell_index_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  gno_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  gno_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .side_i           (side),
    .head_i           (head),
    .fifo_stat_i      (fifo_stat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .direction_o      (direction_o),
    .offset_o         (offset_o),
    .neighbor_index_o (neighbor_index_o),
    .region_o         (region_o),
    .bad_cell_o       (bad_cell_o),
    .last_o           (last_o)
  );

  `GNO_ASSERT_IMP(a_bad_single, out_valid_o && bad_cell_o, last_o && direction_o == '0 && region_o == '0, "out-of-grid item must give one zeroed result")
  `GNO_ASSERT_IMP(a_region_range, out_valid_o && !bad_cell_o, region_o <= REG_W'(8), "region out of range")
  `GNO_ASSERT_IMP(a_offset_nonzero, out_valid_o && !bad_cell_o, offset_o != '0, "neighbour offset is zero")
  `GNO_ASSERT(a_no_push_full, !(push && fifo_stat.full && !pop), "push into full queue")

endmodule
